// ===== hw/rtl/swm_pkg.sv =====
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

	// Sizing
	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int POS_W        = 32;
	localparam int IDX_W        = $clog2(MAX_WINDOW);
	localparam int K_W          = $clog2(MAX_WINDOW + 1);
	localparam int CFG_LEN_W    = 7;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;

	// Register map (word index taken from paddr[2])
	localparam logic REG_WINDOW_LEN = 1'b0;
	localparam logic [CFG_LEN_W-1:0] WINDOW_LEN_RESET = CFG_LEN_W'(3);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		sample_t          window_max;
		logic [POS_W-1:0] window_index;
	} result_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// One cell of the candidate chain: oldest live candidate among the newest samples.
module swm_cell (
	input  logic            clk,
	input  logic            load,
	input  logic            prev_ok,
	input  swm_pkg::sample_t prev_val,
	input  logic            beyond,
	input  swm_pkg::sample_t bcast_val,
	input  swm_pkg::sample_t sample,
	output swm_pkg::sample_t val
);
	import swm_pkg::*;

	sample_t val_q;
	sample_t nxt;

	// Past the window the cell follows the window's head; otherwise the neighbor's
	// candidate survives only if it is strictly above the new sample.
	always_comb begin
		if (beyond) begin
			nxt = bcast_val;
		end else if (prev_ok && (prev_val > sample)) begin
			nxt = prev_val;
		end else begin
			nxt = sample;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

// ===== hw/rtl/swm_out_buf.sv =====
// Two-entry result buffer that decouples the output stall from the input side.
module swm_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  swm_pkg::result_t res_in,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output swm_pkg::result_t res_out
);
	import swm_pkg::*;

	logic [1:0] count_q;
	result_t    e0_q;
	result_t    e1_q;
	logic       pop;

	assign pop       = (count_q != 2'd0) && !out_stall;
	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign res_out   = e0_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Entries: e0 drives the output, e1 holds the overflow
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && (count_q == 2'd1)) begin
				e0_q <= res_in;
			end else begin
				e0_q <= e1_q;
			end
			if (push && (count_q == 2'd2)) begin
				e1_q <= res_in;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				e0_q <= res_in;
			end else begin
				e1_q <= res_in;
			end
		end
	end

endmodule

// ===== hw/rtl/sliding_window_maximum.sv =====
// Sliding window maximum over a signed sample stream, built as a chain of cells.
// A result is registered in the output buffer before it shows on the output.
// One sample per cycle while the output buffer is not full; cell i takes its neighbor's
// candidate on each accepted sample; the head comes from the cell before the window edge.
// Reset clears fill count, position, history flag, output buffer and sets window_len to 3;
// the cell values need no clearing.
module sliding_window_maximum (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample request
	input  logic                          in_valid,
	output logic                          in_stall,
	input  swm_pkg::sample_t              sample,
	input  logic                          start_of_stream,
	// result request
	output logic                          out_valid,
	input  logic                          out_stall,
	output swm_pkg::sample_t              window_max,
	output logic [swm_pkg::POS_W-1:0]     window_index,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swm_pkg::ADDR_W-1:0]    paddr,
	input  logic [swm_pkg::DATA_W-1:0]    pwdata,
	output logic [swm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import swm_pkg::*;

	logic [CFG_LEN_W-1:0] window_len_q;
	logic [K_W-1:0]       fill_q;
	logic [POS_W-1:0]     pos_q;
	logic                 hist_q;

	logic                 in_acc;
	logic                 hist_ok;
	logic [K_W-1:0]       k_eff;
	logic [K_W-1:0]       fill_base;
	logic [K_W-1:0]       fill_nxt;
	logic [POS_W-1:0]     pos_cur;
	logic [IDX_W-1:0]     tap_idx;
	sample_t              tap_val;
	sample_t              head_val;
	logic                 emit;
	logic                 buf_full;
	result_t              res_new;
	result_t              res_out;
	sample_t              cell_val [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] beyond;

	// APB register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN)) begin
			window_len_q <= pwdata[CFG_LEN_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_WINDOW_LEN) begin
			prdata = DATA_W'(window_len_q);
		end else begin
			prdata = '0;
		end
	end

	// Effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_len_q == '0) begin
			k_eff = K_W'(1);
		end else if (int'(window_len_q) > MAX_WINDOW) begin
			k_eff = K_W'(MAX_WINDOW);
		end else begin
			k_eff = K_W'(window_len_q);
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = buf_full;
	assign hist_ok  = hist_q && !start_of_stream;

	// Stream position and fill count after a possible restart
	assign pos_cur   = start_of_stream ? '0 : pos_q;
	assign fill_base = start_of_stream ? '0 : fill_q;
	assign fill_nxt  = (int'(fill_base) < MAX_WINDOW) ? fill_base + K_W'(1) : fill_base;
	assign emit      = (fill_nxt >= k_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			hist_q <= 1'b0;
		end else if (in_acc) begin
			fill_q <= fill_nxt;
			pos_q  <= pos_cur + POS_W'(1);
			hist_q <= 1'b1;
		end
	end

	// Head of the window: the cell one short of the window edge, updated with the new sample
	assign tap_idx = IDX_W'(k_eff - K_W'(2));
	assign tap_val = cell_val[tap_idx];

	always_comb begin
		if (hist_ok && (k_eff >= K_W'(2)) && (tap_val > sample)) begin
			head_val = tap_val;
		end else begin
			head_val = sample;
		end
	end

	// Chain of cells
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		assign beyond[i] = (K_W'(i) >= k_eff);
		if (i == 0) begin : g_first
			swm_cell u_cell (
				.clk       (clk),
				.load      (in_acc),
				.prev_ok   (1'b0),
				.prev_val  (sample),
				.beyond    (beyond[i]),
				.bcast_val (head_val),
				.sample    (sample),
				.val       (cell_val[i])
			);
		end else begin : g_rest
			swm_cell u_cell (
				.clk       (clk),
				.load      (in_acc),
				.prev_ok   (hist_ok),
				.prev_val  (cell_val[i-1]),
				.beyond    (beyond[i]),
				.bcast_val (head_val),
				.sample    (sample),
				.val       (cell_val[i])
			);
		end
	end

	// Result and output buffer
	assign res_new.window_max   = head_val;
	assign res_new.window_index = pos_cur - POS_W'(k_eff) + POS_W'(1);

	swm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc && emit),
		.res_in    (res_new),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign window_max   = res_out.window_max;
	assign window_index = res_out.window_index;

endmodule

// ===== hw/rtl/swm_checker.sv =====
// Port-level checks for the sliding window maximum block, bound to the top level.
module swm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input swm_pkg::sample_t          window_max,
	input logic [swm_pkg::POS_W-1:0] window_index
);
	import swm_pkg::*;

	// Input is held back only while results are pending
	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without pending result");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(window_max) && $stable(window_index)))
		else $error("stalled result changed");

	// No result appears without an accepted sample
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !(in_valid && !in_stall)) |=> !out_valid)
		else $error("result without request");

	// Back-pressure only starts while the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("in_stall rose without output stall");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.window_max   (window_max),
	.window_index (window_index)
);
